@@ sv/nearest_palette_color_matcher_core_macros.svh @@
// assertion macros for the nearest palette color matcher checker
// no dependencies; included by the checker file
`ifndef NEAREST_PALETTE_COLOR_MATCHER_CORE_MACROS_SVH
`define NEAREST_PALETTE_COLOR_MATCHER_CORE_MACROS_SVH

// same-cycle implication, sampled on the rising clock edge outside reset
`define NPCM_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("npcm assertion failed");

// next-cycle implication
`define NPCM_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("npcm assertion failed");

`endif

@@ sv/npcm_pkg.sv @@
// shared types and constants for the nearest palette color matcher
// no dependencies; used by every module of the block
package npcm_pkg;

  localparam int unsigned COLOR_W = 8;
  localparam int unsigned INDEX_W = 8;
  localparam int unsigned SQ_W    = 16;
  localparam int unsigned DIST_W  = 18;

  localparam logic [COLOR_W-1:0] OPAQUE_ALPHA  = 8'hFF;
  localparam logic [COLOR_W-1:0] ALPHA_CLEAR   = 8'h00;
  localparam logic [DIST_W-1:0]  DIST_ALL_ONES = 18'h3FFFF;

  typedef enum logic [1:0] {
    CMD_LOAD    = 2'd0,
    CMD_MATCH   = 2'd1,
    CMD_RESTART = 2'd2
  } cmd_e;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [INDEX_W-1:0] entry_index;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic [COLOR_W-1:0] alpha;
  } in_word_t;

  typedef struct packed {
    logic [INDEX_W-1:0] palette_index;
    logic [COLOR_W-1:0] alpha_out;
    logic               transparent;
    logic               no_match;
    logic [DIST_W-1:0]  distance;
    logic [DIST_W-1:0]  worst_distance;
  } out_word_t;

  // controller to datapath
  typedef struct packed {
    logic               load;
    logic               restart;
    logic               start;
    logic               issue;
    logic [INDEX_W-1:0] addr;
    logic               finish;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic pipe_busy;
    logic out_free;
  } dp_status_t;

endpackage

@@ sv/npcm_ctrl.sv @@
// sequencer for the nearest palette color matcher: accepts words, walks the palette
// depends on npcm_pkg
module npcm_ctrl #(
  parameter int unsigned PALETTE_ENTRIES = 256
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  npcm_pkg::in_word_t    in_word_i,
  output logic                  in_stall_o,
  input  npcm_pkg::dp_status_t  status_i,
  output npcm_pkg::ctrl_cmd_t   cmd_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_FIN   = 2'd3;

  localparam logic [npcm_pkg::INDEX_W-1:0] LastIdx =
    npcm_pkg::INDEX_W'(PALETTE_ENTRIES - 1);

  logic [1:0]                   state_q, state_d;
  logic [npcm_pkg::INDEX_W-1:0] cnt_q, cnt_d;
  logic                         accept;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (in_word_i.cmd)
            npcm_pkg::CMD_LOAD:    cmd_o.load = 1'b1;
            npcm_pkg::CMD_RESTART: cmd_o.restart = 1'b1;
            npcm_pkg::CMD_MATCH: begin
              cmd_o.start = 1'b1;
              cnt_d       = npcm_pkg::INDEX_W'(1);
              // a clear pixel needs no palette walk
              state_d     = (in_word_i.alpha == npcm_pkg::ALPHA_CLEAR) ? ST_FIN : ST_SCAN;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        cmd_o.issue = 1'b1;
        cmd_o.addr  = cnt_q;
        cnt_d       = cnt_q + npcm_pkg::INDEX_W'(1);
        if (cnt_q == LastIdx) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!status_i.pipe_busy) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (status_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

@@ sv/npcm_dp.sv @@
// datapath of the nearest palette color matcher: palette memory, distance pipeline,
// best and worst tracking and the output register; depends on npcm_pkg
module npcm_dp #(
  parameter int unsigned PALETTE_ENTRIES = 256
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  npcm_pkg::in_word_t    in_word_i,
  input  npcm_pkg::ctrl_cmd_t   cmd_i,
  output npcm_pkg::dp_status_t  status_o,
  input  logic                  out_stall_i,
  output logic                  out_valid_o,
  output npcm_pkg::out_word_t   out_word_o
);

  localparam int unsigned IW = $clog2(PALETTE_ENTRIES);
  localparam int unsigned CW = npcm_pkg::COLOR_W;
  localparam int unsigned DW = npcm_pkg::DIST_W;
  localparam int unsigned SW = npcm_pkg::SQ_W;
  localparam int unsigned XW = npcm_pkg::INDEX_W;

  // palette colors; opaque marks live in flops so reset clears them
  logic [3*CW-1:0]            palette_mem [PALETTE_ENTRIES];
  logic [PALETTE_ENTRIES-1:0] opaque_q;

  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic [IW-1:0] rd_addr;

  assign wr_en   = cmd_i.load &&
                   ({1'b0, in_word_i.entry_index} < (XW + 1)'(PALETTE_ENTRIES));
  assign wr_addr = in_word_i.entry_index[IW-1:0];
  assign rd_addr = cmd_i.addr[IW-1:0];

  logic [3*CW-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      palette_mem[wr_addr] <= {in_word_i.red, in_word_i.green, in_word_i.blue};
    end
    if (cmd_i.issue) begin
      rd_q <= palette_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      opaque_q <= '0;
    end else if (wr_en) begin
      opaque_q[wr_addr] <= (in_word_i.alpha == npcm_pkg::OPAQUE_ALPHA);
    end
  end

  // pixel under test
  npcm_pkg::in_word_t px_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      px_q <= in_word_i;
    end
  end

  // stage 1: memory read
  logic          s1_v_q, s1_op_q;
  logic [XW-1:0] s1_idx_q;

  // stage 2: squared channel differences
  logic          s2_v_q;
  logic [XW-1:0] s2_idx_q;
  logic [SW-1:0] sq_r_q, sq_g_q, sq_b_q;
  logic [CW-1:0] d_r, d_g, d_b;
  logic [CW-1:0] e_r, e_g, e_b;

  assign {e_r, e_g, e_b} = rd_q;
  assign d_r = (e_r > px_q.red)   ? e_r - px_q.red   : px_q.red   - e_r;
  assign d_g = (e_g > px_q.green) ? e_g - px_q.green : px_q.green - e_g;
  assign d_b = (e_b > px_q.blue)  ? e_b - px_q.blue  : px_q.blue  - e_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      s1_v_q <= cmd_i.issue;
      s2_v_q <= s1_v_q && s1_op_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_idx_q <= cmd_i.addr;
    s1_op_q  <= opaque_q[rd_addr];
    s2_idx_q <= s1_idx_q;
    sq_r_q   <= SW'(d_r) * SW'(d_r);
    sq_g_q   <= SW'(d_g) * SW'(d_g);
    sq_b_q   <= SW'(d_b) * SW'(d_b);
  end

  // stage 3: sum and keep the first strictly smaller distance
  logic [DW-1:0] sum;
  logic          better;
  logic          found_q;
  logic [DW-1:0] best_q;
  logic [XW-1:0] best_idx_q;

  assign sum    = DW'(sq_r_q) + DW'(sq_g_q) + DW'(sq_b_q);
  assign better = s2_v_q && (!found_q || (sum < best_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (cmd_i.start) begin
      found_q <= 1'b0;
    end else if (better) begin
      found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (better) begin
      best_q     <= sum;
      best_idx_q <= s2_idx_q;
    end
  end

  // result assembly
  logic          trans;
  logic [DW-1:0] res_dist;
  logic [XW-1:0] res_idx;
  logic [DW-1:0] worst_q, worst_d;

  assign trans    = (px_q.alpha == npcm_pkg::ALPHA_CLEAR);
  assign res_dist = trans ? '0 : (found_q ? best_q : npcm_pkg::DIST_ALL_ONES);
  assign res_idx  = (trans || !found_q) ? '0 : best_idx_q;

  always_comb begin
    worst_d = worst_q;
    if (cmd_i.restart) begin
      worst_d = '0;
    end else if (cmd_i.finish && !trans && (res_dist > worst_q)) begin
      worst_d = res_dist;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      worst_q <= '0;
    end else begin
      worst_q <= worst_d;
    end
  end

  // output register
  logic out_valid_q, out_valid_d;

  assign status_o.out_free  = !out_valid_q || !out_stall_i;
  assign status_o.pipe_busy = s1_v_q || s2_v_q;

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (cmd_i.finish) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_word_o.palette_index  <= res_idx;
      out_word_o.alpha_out      <= px_q.alpha;
      out_word_o.transparent    <= trans;
      out_word_o.no_match       <= !trans && !found_q;
      out_word_o.distance       <= res_dist;
      out_word_o.worst_distance <= worst_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ sv/nearest_palette_color_matcher_core.sv @@
// top level of the nearest palette color matcher
// depends on npcm_pkg, npcm_ctrl and npcm_dp
//
// input channel (in_valid_i / in_stall_o / in_data_i) carries one word per command:
//   load writes one palette entry (opaque when alpha is 255, entry 0 never matches,
//   indexes at or past PALETTE_ENTRIES are dropped), restart clears the worst
//   distance, match looks up a pixel; unused command codes are dropped
// output channel (out_valid_o / out_stall_i / out_data_o) carries one word per match
// load, restart and unused words give no output word
// a clear pixel (alpha 0) skips the walk and goes straight to the finish state
// any other pixel walks entries 1 .. PALETTE_ENTRIES-1 through one shared distance
//   pipeline, one entry per cycle, and the block then drains the pipeline; the finish
//   state loads the result into the output register once that is free, and the
//   input reopens as the result is loaded
// results sit in an output register, so new words are taken while a result waits;
//   a stalled receiver only holds up the block when a second result is ready
// reset clears all opaque marks, the worst distance and both handshakes
module nearest_palette_color_matcher_core #(
  parameter int unsigned PALETTE_ENTRIES = 256
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  npcm_pkg::in_word_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output npcm_pkg::out_word_t  out_data_o
);

  npcm_pkg::ctrl_cmd_t  cmd;
  npcm_pkg::dp_status_t status;

  npcm_ctrl #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_word_i  (in_data_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  npcm_dp #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_word_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_data_o)
  );

endmodule

@@ sv/npcm_checker.sv @@
// port-level checks for the nearest palette color matcher, bound to the top level
// depends on npcm_pkg and nearest_palette_color_matcher_core_macros.svh
`include "nearest_palette_color_matcher_core_macros.svh"

module npcm_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input npcm_pkg::in_word_t   in_data_i,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input npcm_pkg::out_word_t  out_data_o
);

  logic in_acc, out_acc;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  // a held result stays put
  `NPCM_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i,
    out_valid_o && $stable(out_data_o))

  // a non-clear pixel lookup keeps the input closed while the palette is walked
  `NPCM_ASSERT_NXT(a_match_busy,
    in_acc && (in_data_i.cmd == npcm_pkg::CMD_MATCH) &&
    (in_data_i.alpha != npcm_pkg::ALPHA_CLEAR), in_stall_o)

  `NPCM_ASSERT_IMP(a_clear_word, out_valid_o && out_data_o.transparent,
    (out_data_o.palette_index == '0) && (out_data_o.distance == '0) &&
    !out_data_o.no_match && (out_data_o.alpha_out == npcm_pkg::ALPHA_CLEAR))

  `NPCM_ASSERT_IMP(a_no_match_word, out_valid_o && out_data_o.no_match,
    (out_data_o.palette_index == '0) &&
    (out_data_o.distance == npcm_pkg::DIST_ALL_ONES) &&
    (out_data_o.worst_distance == npcm_pkg::DIST_ALL_ONES))

  `NPCM_ASSERT_IMP(a_worst_bound, out_acc && !out_data_o.transparent,
    out_data_o.worst_distance >= out_data_o.distance)

endmodule

bind nearest_palette_color_matcher_core npcm_checker u_npcm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
